### rtl/stnt_pkg.sv
`timescale 1ns / 1ps
// Shared constants, function codes and controller/datapath interface types.
package stnt_pkg;

	// Default sizes of the scope stack and of the identifier space.
	localparam int unsigned MAX_SCOPES_DEF = 16;
	localparam int unsigned MAX_IDENTS_DEF = 1024;

	// Fixed widths of the word fields.
	localparam int unsigned FUNC_W  = 3;
	localparam int unsigned IDENT_W = 10;
	localparam int unsigned DEPTH_W = 5;

	// Function codes of an input word.
	localparam logic [FUNC_W-1:0] FN_PUSH      = 3'd0;
	localparam logic [FUNC_W-1:0] FN_POP       = 3'd1;
	localparam logic [FUNC_W-1:0] FN_MARK_TYPE = 3'd2;
	localparam logic [FUNC_W-1:0] FN_MARK_ORD  = 3'd3;
	localparam logic [FUNC_W-1:0] FN_QUERY     = 3'd4;
	localparam logic [FUNC_W-1:0] FN_CLEAR     = 3'd5;

	// Commands from the controller to the datapath, valid for one cycle.
	typedef struct packed {
		logic rd_ident;    // read the mark word of the incoming identifier
		logic exec_wr;     // write back the read word with the new mark set
		logic mark_ord;    // new mark is an ordinary mark, else a type mark
		logic sweep_start; // restart the sweep counter
		logic sweep_pop;   // one step of the pass that clears the popped scope
		logic sweep_zero;  // one step of the pass that zeroes every entry
		logic depth_inc;
		logic depth_dec;
		logic depth_clr;
		logic out_load;    // load the output register with a result word
		logic out_err;
		logic out_query;   // result carries the query answer
	} stnt_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic full;     // every scope is open
		logic empty;    // no scope is open
		logic in_range; // incoming identifier fits the table
		logic cnt_done; // sweep finished, last write retired
		logic out_free; // output register can take a word this cycle
	} stnt_sts_t;

endpackage

### rtl/stnt_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine: decodes words and sequences reads, writes and sweeps.
module stnt_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	input  logic [stnt_pkg::FUNC_W-1:0]   func,
	input  stnt_pkg::stnt_sts_t           sts,
	output logic                          req_stall,
	output stnt_pkg::stnt_cmd_t           cmd
);
	import stnt_pkg::*;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_EXEC,
		ST_POP,
		ST_ZERO
	} state_t;

	state_t state_q, state_d;
	logic   kind_ord_q, kind_ord_d;
	logic   kind_query_q, kind_query_d;
	logic   accept;

	// Next state and per-cycle commands.
	always_comb begin
		cmd          = '0;
		state_d      = state_q;
		kind_ord_d   = kind_ord_q;
		kind_query_d = kind_query_q;
		req_stall    = !((state_q == ST_IDLE) && sts.out_free);
		accept       = req_valid && !req_stall;

		case (state_q)
			ST_INIT: begin
				// Zero the whole table once after reset.
				cmd.sweep_zero = 1'b1;
				if (sts.cnt_done) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					case (func)
						FN_PUSH: begin
							cmd.out_load  = 1'b1;
							cmd.out_err   = sts.full;
							cmd.depth_inc = !sts.full;
						end
						FN_POP: begin
							if (sts.empty) begin
								cmd.out_load = 1'b1;
								cmd.out_err  = 1'b1;
							end else begin
								cmd.depth_dec   = 1'b1;
								cmd.sweep_start = 1'b1;
								state_d         = ST_POP;
							end
						end
						FN_MARK_TYPE, FN_MARK_ORD: begin
							if (sts.empty || !sts.in_range) begin
								cmd.out_load = 1'b1;
								cmd.out_err  = 1'b1;
							end else begin
								cmd.rd_ident = 1'b1;
								kind_ord_d   = (func == FN_MARK_ORD);
								kind_query_d = 1'b0;
								state_d      = ST_EXEC;
							end
						end
						FN_QUERY: begin
							if (sts.in_range) begin
								cmd.rd_ident = 1'b1;
								kind_ord_d   = 1'b0;
								kind_query_d = 1'b1;
								state_d      = ST_EXEC;
							end else begin
								cmd.out_load = 1'b1;
							end
						end
						FN_CLEAR: begin
							cmd.depth_clr   = 1'b1;
							cmd.sweep_start = 1'b1;
							state_d         = ST_ZERO;
						end
						default: begin
							cmd.out_load = 1'b1;
							cmd.out_err  = 1'b1;
						end
					endcase
				end
			end
			ST_EXEC: begin
				// The read word is ready; answer the query or write the mark back.
				if (sts.out_free) begin
					cmd.out_load  = 1'b1;
					cmd.out_query = kind_query_q;
					cmd.exec_wr   = !kind_query_q;
					cmd.mark_ord  = kind_ord_q;
					state_d       = ST_IDLE;
				end
			end
			ST_POP: begin
				cmd.sweep_pop = 1'b1;
				if (sts.cnt_done && sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			ST_ZERO: begin
				cmd.sweep_zero = 1'b1;
				if (sts.cnt_done && sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State and decoded kind of the word in flight.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_INIT;
			kind_ord_q   <= 1'b0;
			kind_query_q <= 1'b0;
		end else begin
			state_q      <= state_d;
			kind_ord_q   <= kind_ord_d;
			kind_query_q <= kind_query_d;
		end
	end

endmodule

### rtl/stnt_dp.sv
`timescale 1ns / 1ps
// Datapath: mark memory, scope depth, sweep counter and output register.
module stnt_dp #(
	parameter int unsigned MAX_SCOPES = stnt_pkg::MAX_SCOPES_DEF,
	parameter int unsigned MAX_IDENTS = stnt_pkg::MAX_IDENTS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [stnt_pkg::IDENT_W-1:0]  ident,
	input  stnt_pkg::stnt_cmd_t           cmd,
	input  logic                          rsp_stall,
	output stnt_pkg::stnt_sts_t           sts,
	output logic                          rsp_valid,
	output logic                          is_type_name,
	output logic                          error,
	output logic [stnt_pkg::DEPTH_W-1:0]  depth
);
	import stnt_pkg::*;

	localparam int unsigned IDX_W  = $clog2(MAX_IDENTS);
	localparam int unsigned CNT_W  = IDX_W + 1;
	localparam int unsigned SD_W   = $clog2(MAX_SCOPES + 1);
	localparam int unsigned WORD_W = 2 * MAX_SCOPES;

	// Each word holds ordinary marks in the upper half, type marks in the lower.
	logic [WORD_W-1:0]     marks_q [MAX_IDENTS];
	logic [WORD_W-1:0]     rd_q;
	logic [IDX_W-1:0]      ident_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [IDX_W-1:0]      wa_s1;
	logic                  wv_s1;
	logic [SD_W-1:0]       depth_q, depth_d;
	logic                  out_valid_q, is_type_q, err_q;
	logic [DEPTH_W-1:0]    depth_out_q;

	logic                  cnt_full;
	logic                  rd_en, wr_en;
	logic [IDX_W-1:0]      rd_addr, wr_addr;
	logic [WORD_W-1:0]     wr_data;
	logic [MAX_SCOPES-1:0] top_bit, pop_bit;
	logic [MAX_SCOPES-1:0] rd_type, rd_ord;
	logic                  answer;
	logic                  out_free;

	assign cnt_full = (cnt_q == CNT_W'(MAX_IDENTS));
	assign out_free = !out_valid_q || !rsp_stall;

	// Status back to the controller.
	always_comb begin
		sts.full     = (depth_q == SD_W'(MAX_SCOPES));
		sts.empty    = (depth_q == '0);
		sts.in_range = (32'(ident) < 32'(MAX_IDENTS));
		sts.cnt_done = cnt_full && !wv_s1;
		sts.out_free = out_free;
	end

	// Scope bits: the innermost open scope, and the scope just popped.
	assign top_bit = MAX_SCOPES'(1) << (depth_q - SD_W'(1));
	assign pop_bit = MAX_SCOPES'(1) << depth_q;

	// Depth after this cycle's command.
	always_comb begin
		depth_d = depth_q;
		if (cmd.depth_clr) begin
			depth_d = '0;
		end else if (cmd.depth_inc) begin
			depth_d = depth_q + SD_W'(1);
		end else if (cmd.depth_dec) begin
			depth_d = depth_q - SD_W'(1);
		end
	end

	// Memory port selection.
	always_comb begin
		rd_en   = cmd.rd_ident || (cmd.sweep_pop && !cnt_full);
		rd_addr = cmd.rd_ident ? IDX_W'(ident) : cnt_q[IDX_W-1:0];
		wr_en   = 1'b0;
		wr_addr = ident_q;
		wr_data = '0;
		if (cmd.exec_wr) begin
			wr_en   = 1'b1;
			wr_data = cmd.mark_ord ? (rd_q | {top_bit, {MAX_SCOPES{1'b0}}})
			                       : (rd_q | {{MAX_SCOPES{1'b0}}, top_bit});
		end else if (wv_s1) begin
			wr_en   = 1'b1;
			wr_addr = wa_s1;
			wr_data = rd_q & ~{pop_bit, pop_bit};
		end else if (cmd.sweep_zero && !cnt_full) begin
			wr_en   = 1'b1;
			wr_addr = cnt_q[IDX_W-1:0];
		end
	end

	// Mark memory with a registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			marks_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= marks_q[rd_addr];
		end
		if (cmd.rd_ident) begin
			ident_q <= IDX_W'(ident);
		end
		if (cmd.sweep_pop) begin
			wa_s1 <= cnt_q[IDX_W-1:0];
		end
	end

	// Query answer: the innermost open scope holding any mark decides.
	assign rd_type = rd_q[MAX_SCOPES-1:0];
	assign rd_ord  = rd_q[WORD_W-1:MAX_SCOPES];

	always_comb begin
		answer = 1'b0;
		for (int s = 0; s < MAX_SCOPES; s++) begin
			if ((SD_W'(s) < depth_q) && (rd_type[s] || rd_ord[s])) begin
				answer = rd_type[s] && !rd_ord[s];
			end
		end
	end

	// Depth, sweep counter and the write-back stage of the pop sweep.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= '0;
			cnt_q   <= '0;
			wv_s1   <= 1'b0;
		end else begin
			depth_q <= depth_d;
			wv_s1   <= cmd.sweep_pop && !cnt_full;
			if (cmd.sweep_start) begin
				cnt_q <= '0;
			end else if ((cmd.sweep_pop || cmd.sweep_zero) && !cnt_full) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

	// Output register; a new word may load while the old one is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			is_type_q   <= cmd.out_query && answer;
			err_q       <= cmd.out_err;
			depth_out_q <= DEPTH_W'(depth_d);
		end
	end

	assign rsp_valid    = out_valid_q;
	assign is_type_name = is_type_q;
	assign error        = err_q;
	assign depth        = depth_out_q;

endmodule

### rtl/scoped_typedef_name_table_core.sv
`timescale 1ns / 1ps
// Top level of the scoped type-name table.
//
// Request channel: req_valid / req_stall carry one word of func and ident.
// Response channel: rsp_valid / rsp_stall carry is_type_name, error and depth.
// Every request word yields exactly one response word, in order.
// Push, failed operations and out-of-range queries respond in the cycle after
// acceptance. Queries and marks read the mark memory and then respond from the
// execute state; a mark writes its word back in that state as well.
// Pop clears the popped scope in every memory entry with a read/write sweep;
// clear all zeroes every entry. Both sweeps use the single memory port pair.
// One request is in work at a time; the next is taken once the response is
// loaded, and only while the output register is empty or is being read.
// After reset the block zeroes the mark memory and holds req_stall high
// meanwhile. A stalled response holds its value and blocks the next response
// from loading until it is taken.
module scoped_typedef_name_table_core #(
	parameter int unsigned MAX_SCOPES = stnt_pkg::MAX_SCOPES_DEF,
	parameter int unsigned MAX_IDENTS = stnt_pkg::MAX_IDENTS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_stall,
	input  logic [stnt_pkg::FUNC_W-1:0]   func,
	input  logic [stnt_pkg::IDENT_W-1:0]  ident,
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output logic                          is_type_name,
	output logic                          error,
	output logic [stnt_pkg::DEPTH_W-1:0]  depth
);
	import stnt_pkg::*;

	stnt_cmd_t cmd;
	stnt_sts_t sts;

	stnt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.func      (func),
		.sts       (sts),
		.req_stall (req_stall),
		.cmd       (cmd)
	);

	stnt_dp #(
		.MAX_SCOPES (MAX_SCOPES),
		.MAX_IDENTS (MAX_IDENTS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ident        (ident),
		.cmd          (cmd),
		.rsp_stall    (rsp_stall),
		.sts          (sts),
		.rsp_valid    (rsp_valid),
		.is_type_name (is_type_name),
		.error        (error),
		.depth        (depth)
	);

	// A failed word never carries a type-name answer.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(error && is_type_name))
		else $error("response flags both error and type name");

	// A response only appears after the controller loaded one.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(cmd.out_load))
		else $error("response word appeared without a load");

	// At most one source writes the mark memory in a cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.exec_wr, cmd.sweep_pop, cmd.sweep_zero}))
		else $error("conflicting mark memory writers");

	// At most one depth update in a cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.depth_inc, cmd.depth_dec, cmd.depth_clr}))
		else $error("conflicting depth updates");

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the scoped type-name table core.
module tb_top;
	import stnt_pkg::*;

	localparam int NSCOPE = MAX_SCOPES_DEF;
	localparam int NIDENT = MAX_IDENTS_DEF;
	localparam int CYCLE_LIMIT = 2_000_000;
	localparam int POOL_SIZE = 8;

	// Function codes that the block does not define.
	localparam logic [FUNC_W-1:0] FN_SPARE_A = 3'd6;
	localparam logic [FUNC_W-1:0] FN_SPARE_B = 3'd7;

	typedef struct packed {
		logic                type_name;
		logic                err;
		logic [DEPTH_W-1:0]  depth;
	} table_rsp_t;

	logic                clk;
	logic                arst_n = 1'b0;
	logic                req_valid = 1'b0;
	logic                req_stall;
	logic [FUNC_W-1:0]   func = '0;
	logic [IDENT_W-1:0]  ident = '0;
	logic                rsp_valid;
	logic                rsp_stall = 1'b0;
	logic                is_type_name;
	logic                error;
	logic [DEPTH_W-1:0]  depth;

	// Predicted table contents: bit s of an entry is the mark of scope s.
	logic [NSCOPE-1:0]   type_mark [NIDENT];
	logic [NSCOPE-1:0]   ord_mark [NIDENT];
	int                  open_scopes;
	table_rsp_t          pending_answers [$];
	logic [IDENT_W-1:0]  ident_pool [POOL_SIZE];

	int                  mismatches = 0;
	int                  cycle_count = 0;
	int                  send_idle_pct = 21;
	int                  recv_stall_pct = 87;

	scoped_typedef_name_table_core u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_stall    (req_stall),
		.func         (func),
		.ident        (ident),
		.rsp_valid    (rsp_valid),
		.rsp_stall    (rsp_stall),
		.is_type_name (is_type_name),
		.error        (error),
		.depth        (depth)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Abort a hung run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycle_count);
			$display("Test completed with failures");
			$finish;
		end
	end

	// Zero every mark and close every scope.
	function automatic void wipe_table();
		for (int i = 0; i < NIDENT; i++) begin
			type_mark[i] = '0;
			ord_mark[i] = '0;
		end
		open_scopes = 0;
	endfunction

	// Drop both marks of one scope in every entry.
	function automatic void drop_scope(input int s);
		for (int i = 0; i < NIDENT; i++) begin
			type_mark[i][s] = 1'b0;
			ord_mark[i][s] = 1'b0;
		end
	endfunction

	// Apply one accepted word to the predicted table and queue its answer.
	function automatic void apply_to_table(input logic [FUNC_W-1:0] f,
			input logic [IDENT_W-1:0] id);
		table_rsp_t r;
		int s;
		bit hit;
		r = '0;
		case (f)
			FN_PUSH: begin
				if (open_scopes >= NSCOPE) begin
					r.err = 1'b1;
				end else begin
					drop_scope(open_scopes);
					open_scopes++;
				end
			end
			FN_POP: begin
				if (open_scopes == 0) begin
					r.err = 1'b1;
				end else begin
					open_scopes--;
					drop_scope(open_scopes);
				end
			end
			FN_MARK_TYPE, FN_MARK_ORD: begin
				if (open_scopes == 0 || int'(id) >= NIDENT) begin
					r.err = 1'b1;
				end else if (f == FN_MARK_TYPE) begin
					type_mark[id][open_scopes-1] = 1'b1;
				end else begin
					ord_mark[id][open_scopes-1] = 1'b1;
				end
			end
			FN_QUERY: begin
				// Innermost scope with any mark decides; an ordinary mark wins.
				if (int'(id) < NIDENT) begin
					hit = 1'b0;
					for (s = open_scopes - 1; s >= 0 && !hit; s--) begin
						if (ord_mark[id][s]) begin
							hit = 1'b1;
						end else if (type_mark[id][s]) begin
							r.type_name = 1'b1;
							hit = 1'b1;
						end
					end
				end
			end
			FN_CLEAR: begin
				wipe_table();
			end
			default: begin
				r.err = 1'b1;
			end
		endcase
		r.depth = DEPTH_W'(open_scopes);
		pending_answers.push_back(r);
	endfunction

	// Present one word, with random idle cycles first, and wait for it to be taken.
	task automatic send_word(input logic [FUNC_W-1:0] f, input logic [IDENT_W-1:0] id);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		func <= f;
		ident <= id;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		apply_to_table(f, id);
	endtask

	// Receiver back-pressure.
	always @(posedge clk) begin
		rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
	end

	// Compare each taken response word with the oldest prediction.
	always @(posedge clk) begin
		table_rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_answers.size() == 0) begin
				$display("%0t: unexpected word: is_type_name=%0b error=%0b depth=%0d",
					$time, is_type_name, error, depth);
				mismatches++;
			end else begin
				want = pending_answers.pop_front();
				if (is_type_name !== want.type_name) begin
					$display("%0t: is_type_name expected %0b actual %0b",
						$time, want.type_name, is_type_name);
					mismatches++;
				end
				if (error !== want.err) begin
					$display("%0t: error expected %0b actual %0b", $time, want.err, error);
					mismatches++;
				end
				if (depth !== want.depth) begin
					$display("%0t: depth expected %0d actual %0d", $time, want.depth, depth);
					mismatches++;
				end
			end
		end
	end

	// Pop, both marks and a query against a table with no open scope, plus the spare codes.
	task automatic test_empty_table();
		send_word(FN_POP, '0);
		send_word(FN_MARK_TYPE, '0);
		send_word(FN_MARK_ORD, '1);
		send_word(FN_QUERY, '1);
		send_word(FN_SPARE_A, 10'h155);
		send_word(FN_SPARE_B, 10'h2aa);
	endtask

	// An inner ordinary mark hides an outer type mark until the inner scope pops.
	task automatic test_shadowing();
		send_word(FN_PUSH, '1);
		send_word(FN_MARK_TYPE, '0);
		send_word(FN_MARK_ORD, '1);
		send_word(FN_QUERY, '0);
		send_word(FN_QUERY, '1);
		send_word(FN_PUSH, '0);
		send_word(FN_MARK_ORD, '0);
		send_word(FN_QUERY, '0);
		send_word(FN_POP, '1);
		send_word(FN_QUERY, '0);
	endtask

	// Fill the stack, push past the limit, mark and query the top scope, then clear all and query.
	task automatic test_depth_limit();
		while (open_scopes < NSCOPE) send_word(FN_PUSH, IDENT_W'($urandom_range(0, NIDENT - 1)));
		send_word(FN_PUSH, '1);
		send_word(FN_MARK_TYPE, '1);
		send_word(FN_QUERY, '1);
		send_word(FN_CLEAR, '1);
		send_word(FN_QUERY, '1);
	endtask

	// Mostly marks and queries on a small set of identifiers, with scope traffic.
	task automatic test_random_traffic(input int n_words);
		int pick;
		logic [IDENT_W-1:0] id;
		for (int i = 0; i < POOL_SIZE; i++) ident_pool[i] = IDENT_W'($urandom_range(0, NIDENT - 1));
		// Run into the depth limit once per phase.
		while (open_scopes < NSCOPE) send_word(FN_PUSH, IDENT_W'($urandom_range(0, NIDENT - 1)));
		send_word(FN_PUSH, IDENT_W'($urandom_range(0, NIDENT - 1)));
		for (int k = 0; k < n_words; k++) begin
			if ($urandom_range(0, 99) < 5)
				ident_pool[$urandom_range(0, POOL_SIZE - 1)] = IDENT_W'($urandom_range(0, NIDENT - 1));
			id = ident_pool[$urandom_range(0, POOL_SIZE - 1)];
			pick = $urandom_range(0, 99);
			if (pick < 12)
				send_word(FN_PUSH, IDENT_W'($urandom_range(0, NIDENT - 1)));
			else if (pick < 18)
				send_word(FN_POP, IDENT_W'($urandom_range(0, NIDENT - 1)));
			else if (pick < 38)
				send_word(FN_MARK_TYPE, id);
			else if (pick < 52)
				send_word(FN_MARK_ORD, id);
			else if (pick < 88)
				send_word(FN_QUERY, id);
			else if (pick < 91)
				send_word(FN_CLEAR, IDENT_W'($urandom_range(0, NIDENT - 1)));
			else if (pick < 94)
				send_word($urandom_range(0, 1) ? FN_SPARE_A : FN_SPARE_B,
					IDENT_W'($urandom_range(0, NIDENT - 1)));
			else
				send_word(FN_QUERY, IDENT_W'($urandom_range(0, NIDENT - 1)));
		end
	endtask

	// Main sequence.
	initial begin
		wipe_table();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_table();
		test_shadowing();
		test_depth_limit();
		test_random_traffic(125);

		send_idle_pct = 87;
		recv_stall_pct = 21;
		test_random_traffic(125);

		send_idle_pct = 0;
		recv_stall_pct = 0;
		test_random_traffic(125);

		req_valid <= 1'b0;
		while (pending_answers.size() != 0) @(posedge clk);
		repeat (NIDENT + 4) @(posedge clk);

		if (mismatches == 0 && pending_answers.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

### filelist.f
rtl/stnt_pkg.sv
rtl/stnt_ctrl.sv
rtl/stnt_dp.sv
rtl/scoped_typedef_name_table_core.sv
tb/sv/tb_top.sv
